// ===== hdl/snapshot_rle_decompressor_assert.svh =====
// Assertion macros for the snapshot RLE decompressor modules; the queue uses them.
`ifndef SNAPSHOT_RLE_DECOMPRESSOR_ASSERT_SVH
`define SNAPSHOT_RLE_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNAPRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SNAPRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/snaprle_pkg.sv =====
// Types, constants and helpers for the snapshot RLE decompressor.
`timescale 1ns / 1ps
`default_nettype none

package snaprle_pkg;

    localparam logic [7:0] RUN_MARK  = 8'hED;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Max tokens one input byte can cause: one decision plus a three byte flush.
    localparam int TOK_MAX   = 4;
    localparam int TOK_IDX_W = $clog2(TOK_MAX);
    localparam int TOK_CNT_W = $clog2(TOK_MAX + 1);

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       marker;
    } t_tok;

    typedef struct packed {
        t_tok [TOK_MAX-1:0]   toks;
        logic [TOK_CNT_W-1:0] ntok;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_tok mk_tok(logic [7:0] value, logic [7:0] count, logic marker);
        t_tok t;
        t.value  = value;
        t.count  = count;
        t.marker = marker;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/snapshot_rle_decompressor.sv =====
// Top level of the snapshot RLE decompressor: front end, queue, back end.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------------
//  in       | sink      | i_in_valid / o_in_stall| i_in_byte, i_in_last
//  out      | source    | o_out_valid/i_out_stall| o_out_value, o_out_count, o_end_marker,
//           |           |                        | o_out_last
//  cfg      | sink      | i_cfg_valid/o_cfg_ready| i_cfg_data (stop_at_marker)
//
// One byte is taken per cycle while the queue has room; each byte turns into 0..4 tokens.
// Unless stalled, the back end sends one token per cycle, popping each batch at its end.
// The first token of a byte passes through the queue memory and then the output register.
// Reset is synchronous: window, flags, queue pointers and output valid clear; cfg reads 0.
// o_in_stall is raised only by a full queue; o_out_valid holds its token while stalled.
`timescale 1ns / 1ps
`default_nettype none

module snapshot_rle_decompressor #(
    parameter int QUEUE_DEPTH = snaprle_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [7:0] i_in_byte,
    input  wire        i_in_last,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_value,
    output logic [7:0] o_out_count,
    output logic       o_end_marker,
    output logic       o_out_last,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_data
);

    snaprle_pkg::t_qstat qstat;
    snaprle_pkg::t_cmd   push_cmd;
    snaprle_pkg::t_cmd   head_cmd;
    logic                push;
    logic                pop;

    snaprle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    snaprle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_stat  (qstat)
    );

    snaprle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_value  (o_out_value),
        .o_out_count  (o_out_count),
        .o_end_marker (o_end_marker),
        .o_out_last   (o_out_last)
    );

endmodule

`default_nettype wire

// ===== hdl/snaprle_front.sv =====
// Front end: byte window, run/marker decision and token batch build.
`timescale 1ns / 1ps
`default_nettype none

module snaprle_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [7:0]          i_in_byte,
    input  wire                 i_in_last,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_data,
    input  snaprle_pkg::t_qstat i_qstat,
    output logic                o_push,
    output snaprle_pkg::t_cmd   o_cmd
);

    logic       r_stop_at_marker;
    logic [7:0] r_win [3];
    logic [7:0] n_win [3];
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       r_stopped;
    logic       n_stopped;

    logic       accept;
    logic [7:0] w [4];
    logic [7:0] kb [3];
    logic [1:0] kfill;
    logic       dec_valid;
    snaprle_pkg::t_tok dec_tok;
    logic       hit_marker;
    logic       hit_run;
    snaprle_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_qstat.full;
    assign accept      = i_in_valid && !i_qstat.full;

    always_comb begin
        // window with the new byte placed after the pending ones
        for (int i = 0; i < 4; i++) begin
            if (i < 3 && i < r_fill)
                w[i] = r_win[i];
            else if (i == r_fill)
                w[i] = i_in_byte;
            else
                w[i] = 8'h00;
        end

        hit_marker = r_stop_at_marker && (w[0] == snaprle_pkg::ZERO_BYTE)
                     && (w[1] == snaprle_pkg::RUN_MARK) && (w[2] == snaprle_pkg::RUN_MARK)
                     && (w[3] == snaprle_pkg::ZERO_BYTE);
        hit_run    = (w[0] == snaprle_pkg::RUN_MARK) && (w[1] == snaprle_pkg::RUN_MARK);

        dec_valid = 1'b0;
        dec_tok   = '0;
        n_stopped = r_stopped;
        kb[0]     = w[0];
        kb[1]     = w[1];
        kb[2]     = w[2];
        kfill     = r_fill + 2'd1;

        if (r_fill == 2'd3) begin
            priority if (hit_marker) begin
                dec_valid = 1'b1;
                dec_tok   = snaprle_pkg::mk_tok(8'h00, 8'h00, 1'b1);
                n_stopped = 1'b1;
                kfill     = 2'd0;
            end else if (hit_run) begin
                // a zero count run yields nothing
                dec_valid = (w[2] != 8'h00);
                dec_tok   = snaprle_pkg::mk_tok(w[3], w[2], 1'b0);
                kfill     = 2'd0;
            end else begin
                dec_valid = 1'b1;
                dec_tok   = snaprle_pkg::mk_tok(w[0], 8'd1, 1'b0);
                kb[0]     = w[1];
                kb[1]     = w[2];
                kb[2]     = w[3];
                kfill     = 2'd3;
            end
        end

        cmd      = '0;
        cmd.last = i_in_last;
        if (!r_stopped) begin
            if (dec_valid) begin
                cmd.toks[0] = dec_tok;
                for (int j = 1; j < 4; j++)
                    cmd.toks[j] = snaprle_pkg::mk_tok(kb[j-1], 8'd1, 1'b0);
            end else begin
                for (int j = 0; j < 3; j++)
                    cmd.toks[j] = snaprle_pkg::mk_tok(kb[j], 8'd1, 1'b0);
            end
            cmd.ntok = {2'b00, dec_valid} + (i_in_last ? {1'b0, kfill} : 3'd0);
        end
        // stream end with nothing to say: one empty token
        if (i_in_last && cmd.ntok == '0) begin
            cmd.toks[0] = '0;
            cmd.ntok    = 3'd1;
        end

        n_win  = r_win;
        n_fill = r_fill;
        if (i_in_last) begin
            n_win[0]  = 8'h00;
            n_win[1]  = 8'h00;
            n_win[2]  = 8'h00;
            n_fill    = 2'd0;
            n_stopped = 1'b0;
        end else if (!r_stopped) begin
            n_win  = kb;
            n_fill = kfill;
        end else begin
            n_stopped = r_stopped;
        end
    end

    assign o_push = accept && (cmd.ntok != '0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_at_marker <= 1'b0;
            r_fill           <= 2'd0;
            r_stopped        <= 1'b0;
            r_win[0]         <= 8'h00;
            r_win[1]         <= 8'h00;
            r_win[2]         <= 8'h00;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                r_stop_at_marker <= i_cfg_data;
            if (accept) begin
                r_win     <= n_win;
                r_fill    <= n_fill;
                r_stopped <= n_stopped;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/snaprle_queue.sv =====
// Small request queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

`include "snapshot_rle_decompressor_assert.svh"

module snaprle_queue #(
    parameter int DEPTH = snaprle_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  snaprle_pkg::t_cmd   i_wdata,
    input  wire                 i_pop,
    output snaprle_pkg::t_cmd   o_rdata,
    output snaprle_pkg::t_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    snaprle_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W:0]    r_wptr;
    logic [PTR_W:0]    r_rptr;
    logic              full;
    logic              empty;

    assign empty = (r_wptr == r_rptr);
    assign full  = (r_wptr[PTR_W] != r_rptr[PTR_W])
                   && (r_wptr[PTR_W-1:0] == r_rptr[PTR_W-1:0]);

    assign o_stat.full  = full;
    assign o_stat.empty = empty;
    assign o_rdata      = r_mem[r_rptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wptr[PTR_W-1:0]] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push)
                r_wptr <= r_wptr + 1'b1;
            if (i_pop)
                r_rptr <= r_rptr + 1'b1;
        end
    end

    `SNAPRLE_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !full, "push into full queue")
    `SNAPRLE_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !empty, "pop from empty queue")
    `SNAPRLE_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !empty, "push lost")
    `SNAPRLE_ASSERT_NOW(a_ntok_range, i_clk, i_rst_n, i_push,
        (i_wdata.ntok != '0) && (i_wdata.ntok <= 3'(snaprle_pkg::TOK_MAX)), "bad token count")

endmodule

`default_nettype wire

// ===== hdl/snaprle_back.sv =====
// Back end: walks each queued batch and presents one token per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module snaprle_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  snaprle_pkg::t_cmd   i_head,
    input  snaprle_pkg::t_qstat i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [7:0]          o_out_value,
    output logic [7:0]          o_out_count,
    output logic                o_end_marker,
    output logic                o_out_last
);

    logic [snaprle_pkg::TOK_IDX_W-1:0] r_idx;
    logic                              r_out_valid;
    snaprle_pkg::t_tok                 r_tok;
    logic                              r_last;
    logic                              load;
    logic                              at_end;

    assign load   = !i_qstat.empty && (!r_out_valid || !i_out_stall);
    assign at_end = ({1'b0, r_idx} == (i_head.ntok - 3'd1));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.toks[r_idx];
            r_last <= i_head.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? '0 : r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_tok.value;
    assign o_out_count  = r_tok.count;
    assign o_end_marker = r_tok.marker;
    assign o_out_last   = r_last;

endmodule

`default_nettype wire

// ===== dv/snapshot_rle_decompressor_test.sv =====
// Self-checking testbench for the snapshot RLE decompressor.
`timescale 1ns / 1ps

module snapshot_rle_decompressor_test;

    localparam int  TOKENS_PER_BYTE = 4;
    localparam int  RANDOM_BYTES    = 245;
    localparam int  MAX_WAIT        = 11;
    localparam int  SETTLE_CYCLES   = 12;
    localparam int  REPORT_LIMIT    = 10;
    localparam real TIMEOUT_NS      = 1000000.0;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       marker;
        logic       last;
    } t_tok;

    typedef enum logic [1:0] {CFG_KEEP, CFG_OFF, CFG_ON} t_cfg_act;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_TOKEN} t_exp_kind;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        t_cfg_act   cfg;
        t_exp_kind  kind;
        t_tok       want;
    } t_plan_row;

    localparam t_tok NO_TOK = '0;
    localparam int   PLAN_ROWS = 27;

    // Directed walk: extremes, runs, zero-count run, marker with the stop on and off,
    // bytes dropped after the marker, marker on the last byte.
    localparam t_plan_row PLAN [0:PLAN_ROWS-1] = '{
        '{8'h00, 1'b1, CFG_OFF,  EXP_TOKEN, '{8'h00, 8'h01, 1'b0, 1'b1}},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h05, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hFF, 1'b1, CFG_KEEP, EXP_TOKEN, '{8'hFF, 8'h05, 1'b0, 1'b1}},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h00, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h77, 1'b1, CFG_KEEP, EXP_TOKEN, '{8'h00, 8'h00, 1'b0, 1'b1}},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hFF, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h00, 1'b1, CFG_KEEP, EXP_TOKEN, '{8'h00, 8'hFF, 1'b0, 1'b1}},
        '{8'h00, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h00, 1'b1, CFG_KEEP, EXP_PRED,  NO_TOK},
        '{8'h00, 1'b0, CFG_ON,   EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h00, 1'b0, CFG_KEEP, EXP_TOKEN, '{8'h00, 8'h00, 1'b1, 1'b0}},
        '{8'h34, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h56, 1'b1, CFG_KEEP, EXP_TOKEN, '{8'h00, 8'h00, 1'b0, 1'b1}},
        '{8'h00, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'hED, 1'b0, CFG_KEEP, EXP_NONE,  NO_TOK},
        '{8'h00, 1'b1, CFG_KEEP, EXP_TOKEN, '{8'h00, 8'h00, 1'b1, 1'b1}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_value;
    logic [7:0] o_out_count;
    logic       o_end_marker;
    logic       o_out_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    // decoder mirror
    logic [7:0] win [3];
    int         win_fill;
    bit         halted;
    bit         stop_en;

    t_tok       expected_tokens [$];
    int         errors;
    int         bytes_sent;
    int         streams_sent;
    int         cfg_writes;
    int         tokens_checked;
    int         run_tokens;
    int         marker_tokens;
    bit         in_quiet;
    bit         out_quiet;

    snapshot_rle_decompressor i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_value  (o_out_value),
        .o_out_count  (o_out_count),
        .o_end_marker (o_end_marker),
        .o_out_last   (o_out_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic t_tok mk_token(logic [7:0] value, logic [7:0] count, logic marker);
        t_tok t;
        t.value  = value;
        t.count  = count;
        t.marker = marker;
        t.last   = 1'b0;
        return t;
    endfunction

    // Tokens caused by one byte; advances the mirrored window.
    task automatic decode_byte(input logic [7:0] b, input bit last,
                               output t_tok toks [TOKENS_PER_BYTE], output int n);
        logic [7:0] w [4];
        int         f;
        n = 0;
        for (int i = 0; i < TOKENS_PER_BYTE; i++) toks[i] = '0;
        if (!halted) begin
            for (int i = 0; i < win_fill; i++) w[i] = win[i];
            w[win_fill] = b;
            f = win_fill + 1;
            if (f == 4) begin
                if (stop_en && w[0] == snaprle_pkg::ZERO_BYTE &&
                        w[1] == snaprle_pkg::RUN_MARK &&
                        w[2] == snaprle_pkg::RUN_MARK &&
                        w[3] == snaprle_pkg::ZERO_BYTE) begin
                    toks[n] = mk_token(8'h00, 8'h00, 1'b1);
                    n++;
                    halted = 1'b1;
                    f = 0;
                end else if (w[0] == snaprle_pkg::RUN_MARK &&
                        w[1] == snaprle_pkg::RUN_MARK) begin
                    // zero count: bytes consumed, nothing emitted
                    if (w[2] != 8'h00) begin
                        toks[n] = mk_token(w[3], w[2], 1'b0);
                        n++;
                    end
                    f = 0;
                end else begin
                    toks[n] = mk_token(w[0], 8'h01, 1'b0);
                    n++;
                    w[0] = w[1];
                    w[1] = w[2];
                    w[2] = w[3];
                    f = 3;
                end
            end
            if (last) begin
                for (int i = 0; i < f; i++) begin
                    toks[n] = mk_token(w[i], 8'h01, 1'b0);
                    n++;
                end
                f = 0;
            end
            for (int i = 0; i < 3; i++) win[i] = (i < f) ? w[i] : 8'h00;
            win_fill = f;
        end
        if (last) begin
            if (n == 0) begin
                toks[n] = mk_token(8'h00, 8'h00, 1'b0);
                n++;
            end
            toks[n-1].last = 1'b1;
            for (int i = 0; i < 3; i++) win[i] = 8'h00;
            win_fill = 0;
            halted = 1'b0;
        end
    endtask

    // Call at a falling edge boundary; returns at the accepting rising edge.
    task automatic send_byte(input logic [7:0] b, input bit last,
                             input t_exp_kind kind, input t_tok want);
        t_tok toks [TOKENS_PER_BYTE];
        int   n;
        repeat (draw_wait(in_quiet)) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(b, last, toks, n);
        bytes_sent++;
        if (kind == EXP_PRED) begin
            for (int i = 0; i < n; i++)
                expected_tokens.insert(expected_tokens.size(), toks[i]);
        end else if (kind == EXP_TOKEN) begin
            expected_tokens.insert(expected_tokens.size(), want);
        end
    endtask

    task automatic drain_out();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bit v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        stop_en = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed pieces; lone marks and broken runs as noise.
    task automatic send_stream();
        logic [7:0] bytes [$];
        int         pieces;
        int         kind;
        logic [7:0] cnt;
        pieces = $urandom_range(1, 8);
        for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
                4, 5: begin
                    case ($urandom_range(0, 7))
                        0:       cnt = 8'h00;
                        1:       cnt = 8'hFF;
                        default: cnt = 8'($urandom_range(1, 255));
                    endcase
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), cnt);
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
                6: begin
                    bytes.insert(bytes.size(), snaprle_pkg::ZERO_BYTE);
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), snaprle_pkg::ZERO_BYTE);
                end
                7: begin
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
                8: begin
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                    bytes.insert(bytes.size(), snaprle_pkg::RUN_MARK);
                end
                default: begin
                    bytes.insert(bytes.size(), snaprle_pkg::ZERO_BYTE);
                end
            endcase
        end
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1, EXP_PRED, NO_TOK);
        streams_sent++;
    endtask

    task automatic note_error(input string what, input t_tok want, input t_tok got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("ERROR %s: expected value=%02h count=%02h marker=%0b last=%0b,",
                     what, want.value, want.count, want.marker, want.last,
                     " got value=%02h count=%02h marker=%0b last=%0b",
                     got.value, got.count, got.marker, got.last);
    endtask

    // token checker
    always @(posedge i_clk) begin : token_check
        t_tok got;
        t_tok want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_value, o_out_count, o_end_marker, o_out_last};
            if (expected_tokens.size() == 0) begin
                note_error("unexpected token", NO_TOK, got);
            end else begin
                want = expected_tokens.pop_front();
                if (got.value !== want.value || got.count !== want.count ||
                        got.marker !== want.marker || got.last !== want.last)
                    note_error("token mismatch", want, got);
            end
            tokens_checked++;
            if (o_end_marker) marker_tokens++;
            if (o_out_count > 8'h01) run_tokens++;
        end
    end

    // downstream backpressure
    initial begin : out_stall_gen
        i_out_stall = 1'b0;
        forever begin
            repeat (draw_wait(out_quiet)) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        in_quiet    = 1'b0;
        out_quiet   = 1'b0;
        errors         = 0;
        bytes_sent     = 0;
        streams_sent   = 0;
        cfg_writes     = 0;
        tokens_checked = 0;
        run_tokens     = 0;
        marker_tokens  = 0;
        halted   = 1'b0;
        stop_en  = 1'b0;
        win_fill = 0;
        for (int i = 0; i < 3; i++) win[i] = 8'h00;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].cfg != CFG_KEEP) begin
                drain_out();
                write_cfg(PLAN[r].cfg == CFG_ON);
            end
            send_byte(PLAN[r].b, PLAN[r].last, PLAN[r].kind, PLAN[r].want);
        end

        while (bytes_sent < PLAN_ROWS + RANDOM_BYTES) begin
            // every fourth stream: hold off until the output is empty, then retune
            if (streams_sent % 4 == 3) begin
                drain_out();
                write_cfg(1'($urandom_range(0, 1)));
            end
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            send_stream();
        end

        drain_out();
        $display("Covered %0d streams, %0d bytes, %0d config writes;", streams_sent,
                 bytes_sent, cfg_writes);
        $display("checked %0d tokens, %0d of them runs and %0d end markers.",
                 tokens_checked, run_tokens, marker_tokens);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
